// File: hdl/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg
// Shared constants, command/status types and modular helpers for the
// subtractive lagged random generator.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned TableLen   = 55;
  localparam int unsigned FillStride = 21;
  localparam int unsigned WarmOffset = 30;
  localparam int unsigned WarmPasses = 4;
  localparam int unsigned TrailStart = 31;

  localparam int unsigned ValueW = 30;
  localparam int unsigned SeedW  = 32;
  localparam int unsigned SlotW  = $clog2(TableLen + 1);
  localparam int unsigned PassW  = $clog2(WarmPasses);

  localparam logic [ValueW-1:0] Modulus  = ValueW'(1000000000);
  localparam logic [SeedW-1:0]  SeedBase = SeedW'(161803398);

  // request codes carried by req_type
  localparam logic ReqReseed = 1'b0;
  localparam logic ReqDraw   = 1'b1;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [SlotW-1:0]  slot_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic  seed_load;
    logic  mod_step;
    logic  fill_first;
    logic  fill_step;
    logic  warm_rd;
    logic  warm_wr;
    slot_t warm_idx;
    logic  draw_rd;
    logic  draw_wr;
    logic  seed_out;
  } srg_cmd_t;

  typedef struct packed {
    logic acc_ge;
    logic out_free;
  } srg_status_t;

  // (a - b) mod 10^9 for a, b below the modulus
  function automatic value_t sub_mod(input value_t a, input value_t b);
    logic [ValueW:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, Modulus} - {1'b0, b};
    end
    return s[ValueW-1:0];
  endfunction

  // advance a slot number, wrapping from the last slot back to the first
  function automatic slot_t bump(input slot_t idx);
    slot_t r;
    if (idx >= SlotW'(TableLen)) begin
      r = SlotW'(1);
    end else begin
      r = idx + SlotW'(1);
    end
    return r;
  endfunction

endpackage

// File: hdl/subtractive_random_generator.sv
// ----------------------------------------------------------------------------
// subtractive_random_generator
// Subtractive lagged generator, modulus 10^9, with reseed and draw requests.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | req_type_i, seed_i
//  out     | output    | out_valid_o / out_stall_i | value_o
//
//  a draw is one registered table read, then subtract and write back
//  a reseed runs the accept cycle, the seed reduction steps, the table fill writes,
//  the warm-up steps, the last warm-up write and the output load
//  after reset the table reads as zero through per-entry valid bits, no sweep
//  a new word is taken while the previous result still waits in the output
//  register; a stalled output holds the sequencer in its final step
// ----------------------------------------------------------------------------
module subtractive_random_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [29:0] value_o
);

  srg_pkg::srg_cmd_t    cmd;
  srg_pkg::srg_status_t status;

  srg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("sequencer idle right after accepting a word");

  a_value_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (value_o < srg_pkg::Modulus))
    else $error("result word not reduced below the modulus");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.draw_wr || cmd.seed_out) |-> (!out_valid_o || !out_stall_i))
    else $error("output register loaded while holding a stalled word");

  a_one_write_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.fill_first, cmd.fill_step, cmd.warm_wr, cmd.draw_wr}))
    else $error("conflicting table write commands");

endmodule

// File: hdl/srg_ctrl.sv
// ----------------------------------------------------------------------------
// srg_ctrl
// Sequencer: takes words in, walks the reseed steps (seed reduction, table
// fill, warm-up passes) and the draw, issuing datapath commands.
// ----------------------------------------------------------------------------
module srg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                req_type_i,
  output logic                in_stall_o,
  input  srg_pkg::srg_status_t status_i,
  output srg_pkg::srg_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StSeedMod,
    StFill,
    StWarm,
    StWarmLast,
    StSeedOut,
    StDrawWr
  } state_e;

  state_e               state_q, state_d;
  srg_pkg::slot_t       step_q, step_d;
  logic [srg_pkg::PassW-1:0] pass_q, pass_d;
  logic                 wr_pend_q, wr_pend_d;
  logic                 accept;
  logic                 last_step;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign last_step  = (step_q == srg_pkg::SlotW'(srg_pkg::TableLen - 1));

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    step_d     = step_q;
    pass_d     = pass_q;
    wr_pend_d  = wr_pend_q;
    cmd_o.warm_idx = step_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_type_i == srg_pkg::ReqReseed) begin
            cmd_o.seed_load = 1'b1;
            state_d         = StSeedMod;
          end else begin
            cmd_o.draw_rd = 1'b1;
            state_d       = StDrawWr;
          end
        end
      end
      StSeedMod: begin
        if (status_i.acc_ge) begin
          cmd_o.mod_step = 1'b1;
        end else begin
          cmd_o.fill_first = 1'b1;
          step_d           = srg_pkg::SlotW'(1);
          state_d          = StFill;
        end
      end
      StFill: begin
        cmd_o.fill_step = 1'b1;
        if (last_step) begin
          step_d    = srg_pkg::SlotW'(1);
          pass_d    = '0;
          wr_pend_d = 1'b0;
          state_d   = StWarm;
        end else begin
          step_d = step_q + srg_pkg::SlotW'(1);
        end
      end
      StWarm: begin
        // read for this step overlaps the write of the previous one
        cmd_o.warm_rd = 1'b1;
        cmd_o.warm_wr = wr_pend_q;
        wr_pend_d     = 1'b1;
        if (last_step) begin
          step_d = srg_pkg::SlotW'(1);
          if (pass_q == srg_pkg::PassW'(srg_pkg::WarmPasses - 1)) begin
            state_d = StWarmLast;
          end else begin
            pass_d = pass_q + srg_pkg::PassW'(1);
          end
        end else begin
          step_d = step_q + srg_pkg::SlotW'(1);
        end
      end
      StWarmLast: begin
        cmd_o.warm_wr = 1'b1;
        state_d       = StSeedOut;
      end
      StSeedOut: begin
        if (status_i.out_free) begin
          cmd_o.seed_out = 1'b1;
          state_d        = StIdle;
        end
      end
      StDrawWr: begin
        if (status_i.out_free) begin
          cmd_o.draw_wr = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      step_q    <= srg_pkg::SlotW'(1);
      pass_q    <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      pass_q    <= pass_d;
      wr_pend_q <= wr_pend_d;
    end
  end

endmodule

// File: hdl/srg_datapath.sv
// ----------------------------------------------------------------------------
// srg_datapath
// Lag table (one write, two registered reads), seed reduction, fill
// recurrence, index registers and the output register.
// ----------------------------------------------------------------------------
module srg_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          seed_i,
  input  srg_pkg::srg_cmd_t    cmd_i,
  output srg_pkg::srg_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [29:0]          value_o
);

  localparam int unsigned Depth = srg_pkg::TableLen;
  localparam int unsigned SlotW = srg_pkg::SlotW;

  // lag table, slot n held at address n-1
  srg_pkg::value_t mem [Depth];
  logic [Depth-1:0] tbl_vld_q;

  logic [srg_pkg::SeedW-1:0] acc_q;
  srg_pkg::value_t cur_q, prev_q, last_q, rd_a_q, rd_b_q, out_value_q;
  srg_pkg::slot_t  pos_q, lead_q, trail_q, wr_addr_q;
  logic            out_valid_q;

  srg_pkg::slot_t  lead_n, trail_n, rd_addr_a, rd_addr_b;
  srg_pkg::slot_t  wr_addr;
  srg_pkg::value_t wr_data, diff;
  logic            wr_en, rd_en;
  logic [SlotW:0]  pos_sum;
  logic [SlotW:0]  partner_sum;

  assign lead_n  = srg_pkg::bump(lead_q);
  assign trail_n = srg_pkg::bump(trail_q);
  assign diff    = srg_pkg::sub_mod(rd_a_q, rd_b_q);
  assign pos_sum = {1'b0, pos_q} + (SlotW + 1)'(srg_pkg::FillStride);
  assign partner_sum = {1'b0, cmd_i.warm_idx} + (SlotW + 1)'(srg_pkg::WarmOffset);

  assign status_o.acc_ge   = (acc_q >= {2'b00, srg_pkg::Modulus});
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign rd_en = cmd_i.warm_rd || cmd_i.draw_rd;

  always_comb begin
    if (cmd_i.draw_rd) begin
      rd_addr_a = lead_n - SlotW'(1);
      rd_addr_b = trail_n - SlotW'(1);
    end else begin
      rd_addr_a = cmd_i.warm_idx - SlotW'(1);
      // partner slot is 1 + (i + 30) mod 55
      if (partner_sum < (SlotW + 1)'(srg_pkg::TableLen)) begin
        rd_addr_b = partner_sum[SlotW-1:0];
      end else begin
        rd_addr_b = SlotW'(partner_sum - (SlotW + 1)'(srg_pkg::TableLen));
      end
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = wr_addr_q;
    wr_data = diff;
    if (cmd_i.fill_first) begin
      wr_addr = SlotW'(srg_pkg::TableLen - 1);
      wr_data = acc_q[srg_pkg::ValueW-1:0];
    end else if (cmd_i.fill_step) begin
      wr_addr = pos_q - SlotW'(1);
      wr_data = prev_q;
    end else if (!(cmd_i.warm_wr || cmd_i.draw_wr)) begin
      wr_en = 1'b0;
    end
  end

  // table storage and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q    <= tbl_vld_q[rd_addr_a] ? mem[rd_addr_a] : '0;
      rd_b_q    <= tbl_vld_q[rd_addr_b] ? mem[rd_addr_b] : '0;
      wr_addr_q <= rd_addr_a;
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
    end else if (wr_en) begin
      tbl_vld_q[wr_addr] <= 1'b1;
    end
  end

  // seed reduction, fill recurrence and output value load
  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_load) begin
      acc_q <= srg_pkg::SeedBase - seed_i;
    end else if (cmd_i.mod_step) begin
      acc_q <= acc_q - {2'b00, srg_pkg::Modulus};
    end
    if (cmd_i.fill_first) begin
      cur_q  <= acc_q[srg_pkg::ValueW-1:0];
      prev_q <= srg_pkg::ValueW'(1);
      pos_q  <= SlotW'(srg_pkg::FillStride);
    end else if (cmd_i.fill_step) begin
      cur_q  <= prev_q;
      prev_q <= srg_pkg::sub_mod(cur_q, prev_q);
      if (pos_sum >= (SlotW + 1)'(srg_pkg::TableLen)) begin
        pos_q <= SlotW'(pos_sum - (SlotW + 1)'(srg_pkg::TableLen));
      end else begin
        pos_q <= pos_sum[SlotW-1:0];
      end
    end
    if (cmd_i.seed_out) begin
      out_value_q <= last_q;
    end else if (cmd_i.draw_wr) begin
      out_value_q <= diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q      <= '0;
      trail_q     <= SlotW'(srg_pkg::TrailStart);
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.seed_load) begin
        lead_q  <= '0;
        trail_q <= SlotW'(srg_pkg::TrailStart);
      end else if (cmd_i.draw_rd) begin
        lead_q  <= lead_n;
        trail_q <= trail_n;
      end
      // after the fill, last value is the final word placed
      if (cmd_i.fill_step) begin
        last_q <= prev_q;
      end else if (cmd_i.draw_wr) begin
        last_q <= diff;
      end
      out_valid_q <= cmd_i.seed_out || cmd_i.draw_wr || (out_valid_q && out_stall_i);
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;

endmodule
